### hdl/mse_pkg.sv
package mse_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_SETUP,
    ST_MERGE,
    ST_ADVANCE,
    ST_PRIME,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the incoming word, or note the overflow
    logic sort_init;  // first pass: run width one, first run, buffer zero as source
    logic setup;      // load the pointers for the next pair of runs
    logic step;       // move one element into the destination buffer
    logic advance;    // go to the next pair of runs, or to the next pass
    logic out_start;  // point the read port at the first sorted element
    logic out_adv;    // the current sorted element has been taken
    logic clear;      // batch finished: drop the count and the overflow flag
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic one_item;   // the batch holds a single element
    logic run_last;   // this merge step writes the last element of the pair
    logic sort_last;  // this advance ends the final pass
    logic out_last;   // the read pointer is at the last sorted element
  } status_t;

endpackage

### hdl/mse_ctrl.sv
module mse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tlast,
  input  logic             m_tready,
  input  mse_pkg::status_t status,
  output mse_pkg::cmd_t    cmd,
  output logic             s_tready,
  output logic             m_tvalid
);
  import mse_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (s_tvalid && s_tlast) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = status.one_item ? ST_PRIME : ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (status.run_last) begin
          state_next = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        state_next = status.sort_last ? ST_PRIME : ST_SETUP;
      end
      ST_PRIME: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready && status.out_last) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_PREP: begin
        cmd.sort_init = 1'b1;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_MERGE: begin
        cmd.step = 1'b1;
      end
      ST_ADVANCE: begin
        cmd.advance = 1'b1;
      end
      ST_PRIME: begin
        cmd.out_start = 1'b1;
      end
      ST_OUT: begin
        m_tvalid    = 1'b1;
        cmd.out_adv = m_tready;
        cmd.clear   = m_tready && status.out_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/mse_dpath.sv
module mse_dpath #(
  parameter int MAX_ITEMS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  mse_pkg::cmd_t    cmd,
  input  logic [31:0]      in_value,
  output mse_pkg::status_t status,
  output logic [31:0]      out_value,
  output logic             out_last,
  output logic             out_overflow
);
  import mse_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = CW + 1;

  // Two buffers: loading fills buffer zero, each pass merges one into the other.
  logic [31:0] mem0 [MAX_ITEMS];
  logic [31:0] mem1 [MAX_ITEMS];
  logic [31:0] rd0a, rd0b, rd1a, rd1b;

  // Batch state.
  logic [CW-1:0] count;
  logic          ovf;

  // Merge state.
  logic          src, src_next;
  logic [PW-1:0] width, width_next;
  logic [PW-1:0] lo, lo_next;
  logic [PW-1:0] i, i_next;
  logic [PW-1:0] j, j_next;
  logic [PW-1:0] k, k_next;
  logic [PW-1:0] mid, mid_next;
  logic [PW-1:0] hi, hi_next;

  logic [PW-1:0] n;
  logic [PW-1:0] mid_calc, hi_calc, lo_step, width_dbl;
  logic          full;
  logic [31:0]   ra, rb;
  logic          take_a;
  logic [31:0]   wdata;
  logic [AW-1:0] waddr;
  logic          we0, we1;

  assign n         = PW'(count);
  assign full      = (count == CW'(MAX_ITEMS));
  assign ra        = src ? rd1a : rd0a;
  assign rb        = src ? rd1b : rd0b;
  assign lo_step   = lo + (width << 1);
  assign width_dbl = width << 1;
  assign mid_calc  = ((lo + width) < n) ? (lo + width) : n;
  assign hi_calc   = (lo_step < n) ? lo_step : n;

  // Pick the smaller head; the left run wins ties.
  assign take_a = (i < mid) && ((j >= hi) || ($signed(ra) <= $signed(rb)));

  // Write port: loading goes to buffer zero, merging to the buffer that is not the source.
  assign wdata = cmd.load ? in_value : (take_a ? ra : rb);
  assign waddr = cmd.load ? count[AW-1:0] : k[AW-1:0];
  assign we0   = (cmd.load && !full) || (cmd.step && src);
  assign we1   = cmd.step && !src;

  // Pointer updates.
  always_comb begin
    src_next   = src;
    width_next = width;
    lo_next    = lo;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    mid_next   = mid;
    hi_next    = hi;
    if (cmd.sort_init) begin
      src_next   = 1'b0;
      width_next = PW'(1);
      lo_next    = '0;
    end
    if (cmd.setup) begin
      i_next   = lo;
      j_next   = mid_calc;
      k_next   = lo;
      mid_next = mid_calc;
      hi_next  = hi_calc;
    end
    if (cmd.step) begin
      i_next = i + PW'(take_a);
      j_next = j + PW'(!take_a);
      k_next = k + PW'(1);
    end
    if (cmd.advance) begin
      if (lo_step >= n) begin
        lo_next    = '0;
        width_next = width_dbl;
        src_next   = ~src;
      end else begin
        lo_next = lo_step;
      end
    end
    if (cmd.out_start) begin
      i_next = '0;
    end
    if (cmd.out_adv) begin
      i_next = i + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    src   <= src_next;
    width <= width_next;
    lo    <= lo_next;
    i     <= i_next;
    j     <= j_next;
    k     <= k_next;
    mid   <= mid_next;
    hi    <= hi_next;
  end

  // Element count and overflow flag for the batch.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  // Buffer zero: one write port, two registered reads.
  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    rd0a <= mem0[i_next[AW-1:0]];
    rd0b <= mem0[j_next[AW-1:0]];
  end

  // Buffer one: same organization.
  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    rd1a <= mem1[i_next[AW-1:0]];
    rd1b <= mem1[j_next[AW-1:0]];
  end

  // Status to the controller and result fields.
  assign status.one_item  = (count == CW'(1));
  assign status.run_last  = ((k + PW'(1)) == hi);
  assign status.sort_last = (lo_step >= n) && (width_dbl >= n);
  assign status.out_last  = ((i + PW'(1)) == n);

  assign out_value    = ra;
  assign out_last     = status.out_last;
  assign out_overflow = ovf;

endmodule

### hdl/merge_sort_engine.sv
// Batch sorter for signed 32-bit words. Words arrive on the slave stream, one per cycle while
// s_tready is high, and s_tlast marks the final word of a batch. The block holds up to MAX_ITEMS
// words; further words of the batch are dropped and the overflow flag (m_tuser) is raised on every
// result of that batch. After the final word, s_tready falls and the batch is sorted into
// ascending order by bottom-up merge passes between two buffers, then streamed out one word per
// cycle while m_tready is high, with m_tlast on the last one; a new batch is accepted only after
// that word is taken. For n stored words the sort takes ceil(log2(n)) passes; each pass sets up,
// merges and advances over every pair of runs in turn, and the destination buffer has a single
// write port, so the merge moves one element per cycle.
module merge_sort_engine #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,   // last_out
  output logic [0:0]  m_tuser    // [0] overflow
);
  import mse_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    ovf_flag;

  mse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid)
  );

  mse_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_value     (s_tdata),
    .status       (status),
    .out_value    (m_tdata),
    .out_last     (m_tlast),
    .out_overflow (ovf_flag)
  );

  assign m_tuser[0] = ovf_flag;

endmodule

### hdl/mse_checker.sv
module mse_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  // Reset leaves the block ready for a new batch with no result pending.
  assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // Loading and readout never overlap.
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while results are pending");

  // The final word of a batch closes the input until the batch is read out.
  assert property (@(posedge clk) disable iff (rst)
      (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still open after final word");

  // Taking the last sorted word reopens the input.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("input not reopened after final result");

  // A stalled result holds its contents.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

### tb/sv/tb_merge_sort_engine.sv
module tb_merge_sort_engine;

  localparam int MAX_ITEMS   = 64;
  localparam int STALL_LIMIT = 5000;

  // One sorted word as the block should present it.
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               ovf;
  } sorted_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] value
  logic        s_tlast;   // last_in
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] sorted_value
  logic        m_tlast;   // last_out
  logic [0:0]  m_tuser;   // [0] overflow

  // Predictor state: the batch being collected and the sorted words still owed.
  logic signed [31:0] batch_words[$];
  logic               batch_overflow;
  sorted_word_t       sorted_expect_q[$];

  int words_sent;
  int words_taken;
  int batches_done;
  int overflow_batches;
  int results_seen;
  int mismatches;
  int idle_cycles;
  bit idle_on;
  int rx_stall_left;

  merge_sort_engine #(.MAX_ITEMS(MAX_ITEMS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver side: ready most of the time, with random stall bursts.
  initial begin
    m_tready = 1'b0;
    rx_stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        rx_stall_left = $urandom_range(1, 18) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Scoreboard: checks each sorted word, then predicts from each accepted input word.
  always @(posedge clk) begin
    sorted_word_t       want;
    logic signed [31:0] key;
    int                 j;
    bit                 moved;
    moved = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        results_seen++;
        if (sorted_expect_q.size() == 0) begin
          $error("unexpected sorted word %h (last %b, overflow %b)", m_tdata, m_tlast,
                 m_tuser[0]);
          mismatches++;
        end else begin
          want = sorted_expect_q.pop_front();
          if (m_tdata !== want.value) begin
            $error("sorted_value: expected %0d, actual %0d", want.value, $signed(m_tdata));
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last_out: expected %b, actual %b", want.last, m_tlast);
            mismatches++;
          end
          if (m_tuser[0] !== want.ovf) begin
            $error("overflow: expected %b, actual %b", want.ovf, m_tuser[0]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        words_taken++;
        // Words beyond capacity are dropped and mark the batch.
        if (batch_words.size() < MAX_ITEMS)
          batch_words.push_back($signed(s_tdata));
        else
          batch_overflow = 1'b1;
        if (s_tlast) begin
          // Ascending signed order; equal values are indistinguishable.
          for (int i = 1; i < batch_words.size(); i++) begin
            key = batch_words[i];
            j = i - 1;
            while (j >= 0 && batch_words[j] > key) begin
              batch_words[j + 1] = batch_words[j];
              j--;
            end
            batch_words[j + 1] = key;
          end
          for (int k = 0; k < batch_words.size(); k++)
            sorted_expect_q.push_back('{value: batch_words[k],
                                        last:  (k == batch_words.size() - 1),
                                        ovf:   batch_overflow});
          batches_done++;
          if (batch_overflow)
            overflow_batches++;
          batch_words.delete();
          batch_overflow = 1'b0;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("merge_sort_engine verification failed");
    $finish;
  end

  // Value mix: small values that collide often, values near the extremes, and anything.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16) - 8;
      1: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fff0) + $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Sends one word; valid stays high between back-to-back words.
  task automatic send_word(input logic [31:0] v, input logic l);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic send_batch(input int n);
    for (int i = 0; i < n; i++)
      send_word(pick_word(), i == n - 1);
  endtask

  // Holds the sender until every owed sorted word has come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sorted_expect_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic test_single_word();
    send_word(32'h8000_0000, 1'b1);
  endtask

  task automatic test_extremes();
    logic [31:0] words[9];
    words = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
              32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0001, 32'h7fff_fffe};
    for (int i = 0; i < 9; i++)
      send_word(words[i], i == 8);
  endtask

  task automatic test_duplicates();
    logic [31:0] words[6];
    words = '{32'd5, 32'd5, -32'sd3, 32'd5, -32'sd3, -32'sd3};
    for (int i = 0; i < 6; i++)
      send_word(words[i], i == 5);
  endtask

  task automatic test_pair_reversed();
    send_word(32'd10, 1'b0);
    send_word(-32'sd10, 1'b1);
  endtask

  // A batch that exactly fills the store raises no overflow.
  task automatic test_full_store();
    send_batch(MAX_ITEMS);
  endtask

  // The final word itself arrives with the store full and is dropped.
  task automatic test_overflow_on_last();
    send_batch(MAX_ITEMS + 1);
  endtask

  task automatic test_overflow_long();
    send_batch(MAX_ITEMS + 6);
  endtask

  // Mostly small batches, a few large ones, and an occasional full drain.
  task automatic test_random_batches(input int word_goal);
    int n;
    while (words_sent < word_goal) begin
      if ($urandom_range(0, 9) == 0)
        n = $urandom_range(20, MAX_ITEMS);
      else
        n = $urandom_range(1, 12);
      send_batch(n);
      if ($urandom_range(0, 5) == 0)
        wait_for_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    idle_on = 1'b0;
    batch_overflow = 1'b0;
    words_sent = 0;
    words_taken = 0;
    batches_done = 0;
    overflow_batches = 0;
    results_seen = 0;
    mismatches = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    test_single_word();
    test_extremes();
    test_duplicates();
    test_pair_reversed();
    wait_for_results();
    test_full_store();
    test_overflow_on_last();
    test_overflow_long();
    test_random_batches(260);
    wait_for_results();
    test_random_batches(270);
    // Closing stretch runs at full rate on both sides.
    idle_on = 1'b0;
    test_random_batches(310);

    wait_for_results();
    repeat (40) @(posedge clk);
    $display("Ran %0d batches: %0d words in, %0d sorted words out, %0d batches overflowed.",
             batches_done, words_taken, results_seen, overflow_batches);
    $display("Covered single words, extremes, duplicates, a full store and dropped finals.");
    if (mismatches == 0) begin
      $display("merge_sort_engine verification clean");
    end else begin
      $display("merge_sort_engine verification failed");
    end
    $finish;
  end

endmodule
